/* design/sli_pkg.sv */
package sli_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IndexWidth = 5;
  localparam int unsigned CountWidth = 6;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [ValueWidth-1:0] value;
    logic [IndexWidth-1:0]        index;
  } req_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [CountWidth-1:0]        count;
    logic [CountWidth-1:0]        removed;
    logic signed [ValueWidth-1:0] read_value;
  } res_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e                     op;
    logic signed [ValueWidth-1:0] value;
  } cell_ctl_t;

endpackage

/* design/sorted_list_insert_delete_core.sv */
// Sorted list of up to CAPACITY signed 32-bit entries, kept in ascending order in a
// row of compare-and-shift cells. Issue a request by raising start_i while busy_o is
// low; the request is taken at that clock edge. Every request yields exactly one
// result on res_o, marked by done_o for a single cycle: the receiver cannot stall it,
// so capture it when done_o is high. Insert, read and the unused kind finish once the request
// is registered and the cells have acted, and busy_o drops in the cycle that carries the
// result; a new request is taken only once busy_o is low. A delete closes the list by one
// position per cycle across the whole cell row, until no entry matches the value. An insert
// into a full list, a delete on an empty list and a read at or beyond the count report their
// status and leave the list alone.
// The read port reaches the first 32 entries, the span of the 5-bit index.
module sorted_list_insert_delete_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sli_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output sli_pkg::res_t res_o
);
  import sli_pkg::*;

  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned XW  = CW + CountWidth;
  localparam int unsigned IW  = (CW > IndexWidth) ? CW : IndexWidth;
  localparam int unsigned RD  = (CAPACITY < 32) ? CAPACITY : 32;
  localparam int unsigned RIW = $clog2(RD);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e       state_q, state_d;
  req_t         req_q, req_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] removed_q, removed_d;
  logic         done_q, done_d;
  res_t         res_q, res_d;

  cell_ctl_t    ctl;
  logic signed [ValueWidth-1:0] cell_v [CAPACITY];
  logic [CAPACITY-1:0] cell_sh, cell_eq;
  logic         any_eq;

  logic [IW-1:0] idx_x, cnt_x;
  logic         rd_ok;
  logic [XW-1:0] count_ext, removed_ext;

  // cell row: each cell sees its left and right neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         prev_sh;
    logic signed [ValueWidth-1:0] prev_v, next_v;

    if (i == 0) begin : g_first
      assign prev_sh = 1'b0;
      assign prev_v  = ctl.value;
    end else begin : g_mid
      assign prev_sh = cell_sh[i-1];
      assign prev_v  = cell_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_v = cell_v[i];
    end else begin : g_inner
      assign next_v = cell_v[i+1];
    end

    sli_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (CW'(i) < count_q),
      .at_count_i (CW'(i) == count_q),
      .prev_sh_i  (prev_sh),
      .prev_v_i   (prev_v),
      .next_v_i   (next_v),
      .v_o        (cell_v[i]),
      .sh_o       (cell_sh[i]),
      .eq_o       (cell_eq[i])
    );
  end

  assign any_eq = |cell_eq;

  // read window over the first entries
  assign idx_x = IW'(req_q.index);
  assign cnt_x = IW'(count_q);
  assign rd_ok = idx_x < cnt_x;

  // count and removed are reported modulo 64
  assign count_ext   = XW'(count_d);
  assign removed_ext = XW'(removed_d);

  // drive the cells: insert in one step, delete one matching entry per step
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.value = req_q.value;
    if (state_q == S_EXEC) begin
      if (req_q.kind == KIND_INSERT && count_q < CW'(CAPACITY)) begin
        ctl.op = CELL_INSERT;
      end else if (req_q.kind == KIND_DELETE && any_eq) begin
        ctl.op = CELL_SHIFT;
      end
    end
  end

  always_comb begin
    logic finish;
    logic [1:0] status;
    logic signed [ValueWidth-1:0] rd;

    state_d   = state_q;
    req_d     = req_q;
    count_d   = count_q;
    removed_d = removed_q;
    done_d    = 1'b0;
    res_d     = res_q;
    finish    = 1'b0;
    status    = STATUS_OK;
    rd        = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d     = req_i;
          removed_d = '0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_q.kind)
          KIND_INSERT: begin
            finish = 1'b1;
            if (count_q < CW'(CAPACITY)) begin
              count_d = count_q + CW'(1);
            end else begin
              status = STATUS_FULL;
            end
          end
          KIND_DELETE: begin
            if (count_q == '0 && removed_q == '0) begin
              status = STATUS_EMPTY;
              finish = 1'b1;
            end else if (any_eq) begin
              // drop one entry, keep going
              count_d   = count_q - CW'(1);
              removed_d = removed_q + CW'(1);
            end else begin
              finish = 1'b1;
            end
          end
          KIND_READ: begin
            finish = 1'b1;
            if (rd_ok) begin
              rd = cell_v[req_q.index[RIW-1:0]];
            end else begin
              status = STATUS_RANGE;
            end
          end
          default: finish = 1'b1;
        endcase

        if (finish) begin
          done_d           = 1'b1;
          state_d          = S_IDLE;
          res_d.status     = status;
          res_d.count      = count_ext[CountWidth-1:0];
          res_d.removed    = removed_ext[CountWidth-1:0];
          res_d.read_value = rd;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= '0;
      count_q   <= '0;
      removed_q <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      req_q     <= req_d;
      count_q   <= count_d;
      removed_q <= removed_d;
      done_q    <= done_d;
      res_q     <= res_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* design/sli_cell.sv */
module sli_cell (
  input  logic                                 clk_i,
  input  sli_pkg::cell_ctl_t                   ctl_i,
  input  logic                                 valid_i,
  input  logic                                 at_count_i,
  input  logic                                 prev_sh_i,
  input  logic signed [sli_pkg::ValueWidth-1:0] prev_v_i,
  input  logic signed [sli_pkg::ValueWidth-1:0] next_v_i,
  output logic signed [sli_pkg::ValueWidth-1:0] v_o,
  output logic                                 sh_o,
  output logic                                 eq_o
);
  import sli_pkg::*;

  logic signed [ValueWidth-1:0] v_q, v_d;
  logic                         ge;

  assign sh_o = valid_i && (ctl_i.value < v_q);
  assign ge   = valid_i && !(v_q < ctl_i.value);
  assign eq_o = valid_i && (v_q == ctl_i.value);
  assign v_o  = v_q;

  always_comb begin
    v_d = v_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        // take the neighbor's entry when the whole tail moves up, else the new value
        if (sh_o || at_count_i) begin
          v_d = prev_sh_i ? prev_v_i : ctl_i.value;
        end
      end
      CELL_SHIFT: begin
        if (ge) begin
          v_d = next_v_i;
        end
      end
      default: v_d = v_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sli_pkg::*;

  localparam int unsigned Capacity    = 32;
  localparam int unsigned RandomItems = 1330;
  localparam int unsigned PoolSize    = 12;
  // margin past the longest delete, which empties a full list
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned ResetCycles = 12;
  // the kind encoding the package leaves unused
  localparam logic [1:0]  KindUnused  = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  res_t res;

  sorted_list_insert_delete_core #(
    .CAPACITY(Capacity)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start_i(start),
    .req_i  (req),
    .busy_o (busy),
    .done_o (done),
    .res_o  (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be issued, and results the list should produce, oldest first.
  req_t request_q[$];
  res_t list_result_q[$];

  // Shadow copy of the sorted list, updated as each request is taken.
  logic signed [ValueWidth-1:0] shadow_list[Capacity];
  int unsigned                  shadow_len = 0;

  int unsigned issued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned idle_left    = 0;
  bit          burst_mode   = 1'b0;
  int unsigned err_cnt      = 0;

  // Run statistics for the closing summary.
  int unsigned n_insert = 0, n_full = 0, n_delete = 0, n_empty = 0, n_removed = 0;
  int unsigned n_read = 0, n_range = 0, n_unused = 0, peak_len = 0;

  // Apply one request to the shadow list and return the result it must produce.
  function automatic res_t apply_to_list(req_t rq);
    res_t                         r;
    logic signed [ValueWidth-1:0] v;
    int unsigned                  pos;
    int unsigned                  kept;
    r = '0;
    v = rq.value;
    r.status = STATUS_OK;
    case (rq.kind)
      KIND_INSERT: begin
        n_insert++;
        if (shadow_len >= Capacity) begin
          // full list: refuse, leave contents alone
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          // place after every entry not greater than the value
          pos = shadow_len;
          for (int i = 0; i < int'(shadow_len); i++) begin
            if (v < shadow_list[i]) begin
              pos = i;
              break;
            end
          end
          for (int i = int'(shadow_len); i > int'(pos); i--) begin
            shadow_list[i] = shadow_list[i-1];
          end
          shadow_list[pos] = v;
          shadow_len++;
        end
      end
      KIND_DELETE: begin
        n_delete++;
        if (shadow_len == 0) begin
          r.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          // drop every equal entry and close the gaps
          kept = 0;
          for (int i = 0; i < int'(shadow_len); i++) begin
            if (shadow_list[i] != v) begin
              shadow_list[kept] = shadow_list[i];
              kept++;
            end
          end
          r.removed = CountWidth'(shadow_len - kept);
          n_removed += shadow_len - kept;
          shadow_len = kept;
        end
      end
      KIND_READ: begin
        n_read++;
        if (rq.index < shadow_len) begin
          r.read_value = shadow_list[rq.index];
        end else begin
          r.status = STATUS_RANGE;
          n_range++;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    r.count = CountWidth'(shadow_len);
    if (shadow_len > peak_len) peak_len = shadow_len;
    return r;
  endfunction

  function automatic req_t make_req(logic [1:0] kind, logic signed [ValueWidth-1:0] value,
                                    logic [IndexWidth-1:0] index);
    req_t r;
    r.kind  = kind;
    r.value = value;
    r.index = index;
    return r;
  endfunction

  // Mostly back-to-back or short gaps, a few long ones; flip into gap-free bursts now and then.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Build the whole request list up front: directed corners first, then random phases
  // that alternately fill the list to capacity and drain it back toward empty.
  initial begin : stimulus
    logic signed [ValueWidth-1:0] pool[PoolSize];
    logic signed [ValueWidth-1:0] v;
    logic [IndexWidth-1:0]        idx;
    logic [1:0]                   kind;
    int unsigned                  phase_left;
    int unsigned                  roll;
    bit                           filling;

    // empty list: delete reports empty, read is out of range, unused kind is harmless
    request_q.push_back(make_req(KIND_DELETE, 32'sd5, '0));
    request_q.push_back(make_req(KIND_READ, '0, '0));
    request_q.push_back(make_req(KindUnused, '0, '0));
    // extremes, zero, minus one and a repeat (repeat lands after its twin)
    request_q.push_back(make_req(KIND_INSERT, 32'h7FFF_FFFF, '0));
    request_q.push_back(make_req(KIND_INSERT, 32'h8000_0000, '0));
    request_q.push_back(make_req(KIND_INSERT, '0, '0));
    request_q.push_back(make_req(KIND_INSERT, '1, '0));
    request_q.push_back(make_req(KIND_INSERT, '0, '1));
    request_q.push_back(make_req(KIND_READ, '0, 5'd0));
    request_q.push_back(make_req(KIND_READ, '0, 5'd1));
    request_q.push_back(make_req(KIND_READ, '0, 5'd4));
    request_q.push_back(make_req(KIND_READ, '0, 5'd5));
    request_q.push_back(make_req(KIND_READ, '1, 5'd31));
    // delete a repeated value, then one that is absent
    request_q.push_back(make_req(KIND_DELETE, '0, '0));
    request_q.push_back(make_req(KIND_DELETE, 32'sd12345, '0));
    request_q.push_back(make_req(KindUnused, '1, '1));
    // remove the extremes, leaving minus one only
    request_q.push_back(make_req(KIND_DELETE, 32'h8000_0000, '0));
    request_q.push_back(make_req(KIND_DELETE, 32'h7FFF_FFFF, '0));
    request_q.push_back(make_req(KIND_READ, '0, 5'd0));

    // a small value pool makes repeats and matching deletes common
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = '0;
    pool[3] = '1;
    pool[4] = 32'sd1;
    for (int i = 5; i < int'(PoolSize); i++) pool[i] = $urandom;

    filling    = 1'b0;
    phase_left = 0;
    repeat (RandomItems) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = filling ? $urandom_range(40, 90) : $urandom_range(20, 50);
        pool[$urandom_range(5, PoolSize - 1)] = $urandom;
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (filling) begin
        if (roll < 82)      kind = KIND_INSERT;
        else if (roll < 88) kind = KIND_DELETE;
        else if (roll < 98) kind = KIND_READ;
        else                kind = KindUnused;
      end else begin
        if (roll < 30)      kind = KIND_INSERT;
        else if (roll < 70) kind = KIND_DELETE;
        else if (roll < 96) kind = KIND_READ;
        else                kind = KindUnused;
      end
      if ($urandom_range(0, 99) < 75) v = pool[$urandom_range(0, PoolSize - 1)];
      else                            v = $urandom;
      if ($urandom_range(0, 1) == 0) idx = IndexWidth'($urandom_range(0, 31));
      else                           idx = IndexWidth'($urandom_range(0, 15));
      request_q.push_back(make_req(kind, v, idx));
    end
  end

  // Driver: change inputs on the falling edge. Hold start until the request is taken,
  // then either present the next one at once or idle for a random gap.
  always @(negedge clk) begin : driver
    logic next_start;
    next_start = start;
    if (rst_n) begin
      if (start && accepted_cnt == issued_cnt) begin
        next_start = 1'b0;
        idle_left  = pick_gap();
      end
      if (!next_start && request_q.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else begin
          req <= request_q.pop_front();
          issued_cnt++;
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  // Acceptance: a request is taken at a rising edge with start high and busy low.
  // Predict its result right here so the shadow list tracks the block's order exactly.
  always @(posedge clk) begin : accept
    if (rst_n && start && !busy) begin
      list_result_q.push_back(apply_to_list(req));
      accepted_cnt++;
    end
  end

  // Monitor: every done pulse carries one result; compare it with the oldest prediction.
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n && done) begin
      if (list_result_q.size() == 0) begin
        $error("unexpected result: status %0d count %0d removed %0d read_value %0d",
               res.status, res.count, res.removed, res.read_value);
        err_cnt++;
      end else begin
        want = list_result_q.pop_front();
        if (res.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res.status);
          err_cnt++;
        end
        if (res.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, res.count);
          err_cnt++;
        end
        if (res.removed !== want.removed) begin
          $error("removed: expected %0d, actual %0d", want.removed, res.removed);
          err_cnt++;
        end
        if (res.read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value, res.read_value);
          err_cnt++;
        end
      end
    end
  end

  // Run control: release reset, wait for every request to be taken and answered,
  // then let a delete's worth of cycles pass so a stray result would still be caught.
  initial begin : run_ctl
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    while (request_q.size() > 0 || accepted_cnt != issued_cnt) @(posedge clk);
    while (list_result_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d requests: %0d inserts (%0d refused full),",
             accepted_cnt, n_insert, n_full);
    $display("  %0d deletes (%0d on empty, %0d entries removed),",
             n_delete, n_empty, n_removed);
    $display("  %0d reads (%0d beyond count), %0d unused-kind requests, peak %0d entries",
             n_read, n_range, n_unused, peak_len);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: stop a run that hangs and report it as a mismatch.
  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results outstanding", list_result_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
design/sli_pkg.sv
design/sli_cell.sv
design/sorted_list_insert_delete_core.sv
test/tb_top.sv
